// ===== sv/flci_pkg.sv =====
// Shared types, constants and control store for the flash command interface.
package flci_pkg;

	localparam int ADDR_BITS  = 19;
	localparam int ARRAY_SIZE = 1 << ADDR_BITS;

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [ADDR_BITS:0]   cnt_t;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_UNLOCK1,
		MODE_UNLOCK2,
		MODE_PROGRAM,
		MODE_ERASE_SETUP,
		MODE_ERASE_UNLOCK,
		MODE_ERASE
	} mode_t;

	localparam addr_t CMD_ADDR1       = addr_t'(24'h000aaa);
	localparam addr_t CMD_ADDR2       = addr_t'(24'h000555);
	localparam addr_t ERASE_LOW_ADDR  = addr_t'(24'h000000);
	localparam addr_t ERASE_SECT_A    = addr_t'(24'h020000);
	localparam addr_t ERASE_SECT_B    = addr_t'(24'h030000);
	localparam cnt_t  ERASE_LOW_COUNT  = cnt_t'(24'h007fff);
	localparam cnt_t  ERASE_SECT_COUNT = cnt_t'(24'h00ffff);
	localparam cnt_t  FULL_COUNT       = cnt_t'(ARRAY_SIZE);

	localparam logic [7:0] DATA_UNLOCK1 = 8'haa;
	localparam logic [7:0] DATA_UNLOCK2 = 8'h55;
	localparam logic [7:0] DATA_PROGRAM = 8'ha0;
	localparam logic [7:0] DATA_ERASE   = 8'h80;
	localparam logic [7:0] DATA_RESET   = 8'hf0;
	localparam logic [7:0] ERASED_BYTE  = 8'hff;
	localparam logic [7:0] STATUS_ERASE = 8'h80;

	typedef struct packed {
		logic        op;
		logic [7:0]  segment;
		logic [15:0] offset;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       unknown_command;
	} rsp_t;

	typedef struct packed {
		mode_t mode_next;
		logic  unknown;
		logic  prog;
		logic  erase;
		addr_t erase_start;
		cnt_t  erase_count;
	} cmd_res_t;

	typedef enum logic [1:0] {
		UPC_INIT,
		UPC_FILL,
		UPC_FETCH,
		UPC_RESP
	} upc_t;

	typedef enum logic [1:0] {
		COND_ALWAYS,
		COND_FILL_DONE,
		COND_ADVANCE,
		COND_ERASE_PEND
	} cond_t;

	typedef struct packed {
		logic  accept;
		logic  fill;
		logic  init_walk;
		logic  load_resp;
		cond_t cond;
		upc_t  tgt_true;
		upc_t  tgt_false;
	} ucode_t;

	typedef struct packed {
		logic fill_done;
		logic advance;
		logic erase_pend;
	} seq_flags_t;

	function automatic ucode_t ucode_rom(upc_t pc);
		ucode_t w;
		w = '{accept: 1'b0, fill: 1'b0, init_walk: 1'b0, load_resp: 1'b0,
			cond: COND_ALWAYS, tgt_true: UPC_FETCH, tgt_false: UPC_FETCH};
		unique case (pc)
			UPC_INIT: begin
				w.init_walk = 1'b1;
				w.cond      = COND_ALWAYS;
				w.tgt_true  = UPC_FILL;
				w.tgt_false = UPC_FILL;
			end
			UPC_FILL: begin
				w.fill      = 1'b1;
				w.cond      = COND_FILL_DONE;
				w.tgt_true  = UPC_FETCH;
				w.tgt_false = UPC_FILL;
			end
			UPC_FETCH: begin
				w.accept    = 1'b1;
				w.cond      = COND_ADVANCE;
				w.tgt_true  = UPC_RESP;
				w.tgt_false = UPC_FETCH;
			end
			UPC_RESP: begin
				w.load_resp = 1'b1;
				w.cond      = COND_ERASE_PEND;
				w.tgt_true  = UPC_FILL;
				w.tgt_false = UPC_FETCH;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== sv/flci_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module flci_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/flci_cmd.sv =====
// Command sequence decoder: next mode, unknown-command flag, program and erase requests.
module flci_cmd (
	input  flci_pkg::mode_t    mode,
	input  flci_pkg::addr_t    addr,
	input  logic [7:0]         data,
	output flci_pkg::cmd_res_t res
);

	logic matched;

	always_comb begin
		res.mode_next   = mode;
		res.unknown     = 1'b0;
		res.prog        = 1'b0;
		res.erase       = 1'b0;
		res.erase_start = '0;
		res.erase_count = '0;
		matched         = 1'b0;
		unique case (mode)
			flci_pkg::MODE_IDLE: begin
				if (addr == flci_pkg::CMD_ADDR1 && data == flci_pkg::DATA_UNLOCK1) begin
					res.mode_next = flci_pkg::MODE_UNLOCK1;
					matched       = 1'b1;
				end
			end
			flci_pkg::MODE_UNLOCK1: begin
				if (addr == flci_pkg::CMD_ADDR2 && data == flci_pkg::DATA_UNLOCK2) begin
					res.mode_next = flci_pkg::MODE_UNLOCK2;
					matched       = 1'b1;
				end
			end
			flci_pkg::MODE_UNLOCK2: begin
				if (addr == flci_pkg::CMD_ADDR1 && data == flci_pkg::DATA_PROGRAM) begin
					res.mode_next = flci_pkg::MODE_PROGRAM;
					matched       = 1'b1;
				end else if (addr == flci_pkg::CMD_ADDR1 && data == flci_pkg::DATA_ERASE) begin
					res.mode_next = flci_pkg::MODE_ERASE_SETUP;
					matched       = 1'b1;
				end
			end
			flci_pkg::MODE_PROGRAM: begin
				res.prog      = 1'b1;
				res.mode_next = flci_pkg::MODE_IDLE;
				matched       = 1'b1;
			end
			flci_pkg::MODE_ERASE_SETUP: begin
				if (addr == flci_pkg::CMD_ADDR1 && data == flci_pkg::DATA_UNLOCK1) begin
					res.mode_next = flci_pkg::MODE_ERASE_UNLOCK;
					matched       = 1'b1;
				end
			end
			flci_pkg::MODE_ERASE_UNLOCK: begin
				if (addr == flci_pkg::CMD_ADDR2 && data == flci_pkg::DATA_UNLOCK2) begin
					res.mode_next = flci_pkg::MODE_ERASE;
					matched       = 1'b1;
				end
			end
			flci_pkg::MODE_ERASE: begin
				matched = 1'b1;
				if (addr == flci_pkg::ERASE_LOW_ADDR) begin
					res.erase       = 1'b1;
					res.erase_start = flci_pkg::ERASE_LOW_ADDR;
					res.erase_count = flci_pkg::ERASE_LOW_COUNT;
				end else if (addr == flci_pkg::ERASE_SECT_A || addr == flci_pkg::ERASE_SECT_B) begin
					res.erase       = 1'b1;
					res.erase_start = addr;
					res.erase_count = flci_pkg::ERASE_SECT_COUNT;
				end
			end
			default: begin
			end
		endcase
		if (!matched) begin
			if (data == flci_pkg::DATA_RESET) begin
				res.mode_next = flci_pkg::MODE_IDLE;
			end else begin
				res.unknown = 1'b1;
			end
		end
	end

endmodule

// ===== sv/flci_seq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module flci_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  flci_pkg::seq_flags_t flags,
	output flci_pkg::ucode_t     ctrl
);

	flci_pkg::upc_t upc_q;
	logic           cond_met;

	assign ctrl = flci_pkg::ucode_rom(upc_q);

	always_comb begin
		unique case (ctrl.cond)
			flci_pkg::COND_ALWAYS:     cond_met = 1'b1;
			flci_pkg::COND_FILL_DONE:  cond_met = flags.fill_done;
			flci_pkg::COND_ADVANCE:    cond_met = flags.advance;
			flci_pkg::COND_ERASE_PEND: cond_met = flags.erase_pend;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= flci_pkg::UPC_INIT;
		end else begin
			upc_q <= cond_met ? ctrl.tgt_true : ctrl.tgt_false;
		end
	end

endmodule

// ===== sv/flash_command_interface_top.sv =====
// Top level of the flash command interface: datapath, mode register and flash array.
//
// Channels: req (req_valid/req_ready) carries one bus access per transfer,
// rsp (rsp_valid/rsp_ready) returns exactly one result per access, in order.
// A write's result is registered in the cycle of its transfer and is shown
// in the next cycle; a read's data passes through the registered read port
// of the flash array and is then loaded into the result register in the
// following step of the control program.
// Writes are taken one per cycle while rsp is not stalled; after a read the
// control program runs its response step before fetching a new request.
// An erase walks the array one byte a cycle through the single write port:
// 0x7fff or 0xffff bytes (clipped at the array end), with req held off
// meanwhile; its result is already in the result register.
// After reset the array is filled with FF by the same walk, one byte a cycle,
// over all 2^ADDR_BITS bytes (524288), before req_ready first rises.
// The mode returns to idle at reset.
// While rsp is stalled with a result pending, req_ready stays low; the result
// holds until its transfer.
module flash_command_interface_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  flci_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output flci_pkg::rsp_t   rsp
);

	flci_pkg::ucode_t     ctrl;
	flci_pkg::seq_flags_t flags;
	flci_pkg::cmd_res_t   cmd;
	flci_pkg::mode_t      mode_q;
	flci_pkg::addr_t      addr;
	flci_pkg::addr_t      walk_addr_q;
	flci_pkg::cnt_t       walk_cnt_q;
	flci_pkg::rsp_t       rsp_q;
	logic [23:0]          full_addr;
	logic                 rsp_valid_q;
	logic                 pend_erase_q;
	logic                 pend_status_q;
	logic                 req_acc;
	logic                 wr_acc;
	logic                 rd_acc;
	logic                 fill_done;
	logic                 load_read;
	logic                 ram_we;
	flci_pkg::addr_t      ram_waddr;
	logic [7:0]           ram_wdata;
	logic [7:0]           ram_rdata;

	assign full_addr = {req.segment, req.offset};
	assign addr      = full_addr[flci_pkg::ADDR_BITS-1:0];

	assign req_ready = ctrl.accept && (!rsp_valid_q || rsp_ready);
	assign req_acc   = req_valid && req_ready;
	assign wr_acc    = req_acc && (req.op == flci_pkg::OP_WRITE);
	assign rd_acc    = req_acc && (req.op == flci_pkg::OP_READ);
	assign fill_done = (walk_cnt_q == flci_pkg::cnt_t'(1)) || (&walk_addr_q);
	assign load_read = ctrl.load_resp && !pend_erase_q;

	assign flags.fill_done  = fill_done;
	assign flags.advance    = rd_acc || (wr_acc && cmd.erase);
	assign flags.erase_pend = pend_erase_q;

	flci_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	flci_cmd u_cmd (
		.mode (mode_q),
		.addr (addr),
		.data (req.write_data),
		.res  (cmd)
	);

	assign ram_we    = ctrl.fill || (wr_acc && cmd.prog);
	assign ram_waddr = ctrl.fill ? walk_addr_q : addr;
	assign ram_wdata = ctrl.fill ? flci_pkg::ERASED_BYTE : req.write_data;

	flci_ram #(
		.WIDTH (8),
		.DEPTH (flci_pkg::ARRAY_SIZE)
	) u_array (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_acc),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= flci_pkg::MODE_IDLE;
			rsp_valid_q   <= 1'b0;
			pend_erase_q  <= 1'b0;
			pend_status_q <= 1'b0;
		end else begin
			if (wr_acc) begin
				mode_q <= cmd.mode_next;
			end else if (rd_acc && mode_q == flci_pkg::MODE_ERASE) begin
				mode_q <= flci_pkg::MODE_IDLE;
			end
			if (req_acc) begin
				pend_erase_q  <= wr_acc && cmd.erase;
				pend_status_q <= rd_acc && (mode_q == flci_pkg::MODE_ERASE);
			end
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (wr_acc || load_read) begin
				rsp_valid_q <= 1'b1;
			end
		end
	end

	// Walk counters for the reset fill and erases
	always_ff @(posedge clk) begin
		if (ctrl.init_walk) begin
			walk_addr_q <= '0;
			walk_cnt_q  <= flci_pkg::FULL_COUNT;
		end else if (wr_acc && cmd.erase) begin
			walk_addr_q <= cmd.erase_start;
			walk_cnt_q  <= cmd.erase_count;
		end else if (ctrl.fill) begin
			walk_addr_q <= walk_addr_q + flci_pkg::addr_t'(1);
			walk_cnt_q  <= walk_cnt_q - flci_pkg::cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_acc) begin
			rsp_q.read_data       <= '0;
			rsp_q.unknown_command <= cmd.unknown;
		end else if (load_read) begin
			rsp_q.read_data       <= pend_status_q ? flci_pkg::STATUS_ERASE : ram_rdata;
			rsp_q.unknown_command <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== test/tb_flash_command_interface_top.sv =====
// Self-checking bench for the flash command interface: command sequences, program, erase, reads.
`timescale 1ns / 1ps

module tb_flash_command_interface_top;
	import flci_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int PHASE_ITEMS = 125;

	class flash_access_scoreboard;
		mode_t      mode;
		logic [7:0] flash_image [ARRAY_SIZE];
		rsp_t       expected_results [$];
		int         mismatches;

		function new();
			mode = MODE_IDLE;
			mismatches = 0;
			foreach (flash_image[i])
				flash_image[i] = ERASED_BYTE;
		endfunction

		function void erase_fill(int unsigned start, int unsigned count);
			if (start >= ARRAY_SIZE)
				return;
			if (count > ARRAY_SIZE - start)
				count = ARRAY_SIZE - start;
			for (int unsigned i = 0; i < count; i++)
				flash_image[start + i] = ERASED_BYTE;
		endfunction

		function bit apply_write(addr_t addr, logic [7:0] data);
			bit matched;
			matched = 1'b0;
			case (mode)
				MODE_IDLE: if (addr == CMD_ADDR1 && data == DATA_UNLOCK1) begin
					mode = MODE_UNLOCK1;
					matched = 1'b1;
				end
				MODE_UNLOCK1: if (addr == CMD_ADDR2 && data == DATA_UNLOCK2) begin
					mode = MODE_UNLOCK2;
					matched = 1'b1;
				end
				MODE_UNLOCK2: if (addr == CMD_ADDR1 && data == DATA_PROGRAM) begin
					mode = MODE_PROGRAM;
					matched = 1'b1;
				end else if (addr == CMD_ADDR1 && data == DATA_ERASE) begin
					mode = MODE_ERASE_SETUP;
					matched = 1'b1;
				end
				MODE_PROGRAM: begin
					flash_image[addr] = data;
					mode = MODE_IDLE;
					return 1'b0;
				end
				MODE_ERASE_SETUP: if (addr == CMD_ADDR1 && data == DATA_UNLOCK1) begin
					mode = MODE_ERASE_UNLOCK;
					matched = 1'b1;
				end
				MODE_ERASE_UNLOCK: if (addr == CMD_ADDR2 && data == DATA_UNLOCK2) begin
					mode = MODE_ERASE;
					matched = 1'b1;
				end
				MODE_ERASE: begin
					if (addr == ERASE_LOW_ADDR)
						erase_fill(int'(addr), int'(ERASE_LOW_COUNT));
					if (addr == ERASE_SECT_A || addr == ERASE_SECT_B)
						erase_fill(int'(addr), int'(ERASE_SECT_COUNT));
					return 1'b0;
				end
				default: ;
			endcase
			if (matched)
				return 1'b0;
			if (data == DATA_RESET) begin
				mode = MODE_IDLE;
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_access(req_t access);
			logic [23:0] full;
			addr_t       addr;
			rsp_t        res;
			full = {access.segment, 16'h0000} + {8'h00, access.offset};
			addr = full[ADDR_BITS-1:0];
			res = '0;
			if (access.op == OP_READ) begin
				if (mode == MODE_ERASE) begin
					mode = MODE_IDLE;
					res.read_data = STATUS_ERASE;
				end else begin
					res.read_data = flash_image[addr];
				end
			end else begin
				res.unknown_command = apply_write(addr, access.write_data);
			end
			expected_results.push_back(res);
		endfunction

		task report_mismatch(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		task check_result(rsp_t got);
			rsp_t want;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %h with no access outstanding", got));
				return;
			end
			want = expected_results.pop_front();
			if (got.read_data !== want.read_data)
				report_mismatch($sformatf("read_data %h, predicted %h",
					got.read_data, want.read_data));
			if (got.unknown_command !== want.unknown_command)
				report_mismatch($sformatf("unknown_command %b, predicted %b",
					got.unknown_command, want.unknown_command));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	flash_access_scoreboard sb;
	int    req_idle_pct;
	int    rsp_stall_pct;
	int    cycle_count;
	int    erases_left [3];
	addr_t erase_addrs [3];
	addr_t recent_addrs [$];
	addr_t boundary_addrs [14];

	flash_command_interface_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic req_t make_access(logic op, addr_t addr, logic [7:0] data);
		logic [23:0] full;
		req_t        r;
		full = 24'($urandom_range(255)) << 16;
		full[ADDR_BITS-1:0] = addr;
		r.op = op;
		r.segment = full[23:16];
		r.offset = full[15:0];
		r.write_data = data;
		return r;
	endfunction

	function automatic addr_t pick_addr();
		int    roll;
		addr_t base;
		roll = $urandom_range(99);
		base = boundary_addrs[$urandom_range(13)];
		if (roll < 40) begin
			if (recent_addrs.size() != 0 && $urandom_range(1))
				return recent_addrs[$urandom_range(recent_addrs.size() - 1)];
			return base;
		end
		if (roll < 70)
			return base + addr_t'($urandom_range(16)) - addr_t'(8);
		return addr_t'($urandom);
	endfunction

	function automatic logic [7:0] pick_data();
		int roll;
		roll = $urandom_range(99);
		if (roll < 20)
			return DATA_RESET;
		if (roll < 40) begin
			case ($urandom_range(3))
				0: return DATA_UNLOCK1;
				1: return DATA_UNLOCK2;
				2: return DATA_PROGRAM;
				default: return DATA_ERASE;
			endcase
		end
		return 8'($urandom_range(255));
	endfunction

	function automatic req_t noise_access();
		addr_t a;
		if ($urandom_range(99) < 30)
			a = $urandom_range(1) ? CMD_ADDR1 : CMD_ADDR2;
		else
			a = pick_addr();
		return make_access(1'($urandom_range(1)), a, pick_data());
	endfunction

	function automatic req_t next_random_access();
		int    roll;
		int    kind;
		addr_t a;
		roll = $urandom_range(99);
		case (sb.mode)
			MODE_IDLE: if (roll < 70)
				return make_access(OP_WRITE, CMD_ADDR1, DATA_UNLOCK1);
			MODE_UNLOCK1: if (roll < 80)
				return make_access(OP_WRITE, CMD_ADDR2, DATA_UNLOCK2);
			MODE_UNLOCK2: if (roll < 45)
				return make_access(OP_WRITE, CMD_ADDR1, DATA_PROGRAM);
			else if (roll < 85)
				return make_access(OP_WRITE, CMD_ADDR1, DATA_ERASE);
			MODE_ERASE_SETUP: if (roll < 85)
				return make_access(OP_WRITE, CMD_ADDR1, DATA_UNLOCK1);
			MODE_ERASE_UNLOCK: if (roll < 85)
				return make_access(OP_WRITE, CMD_ADDR2, DATA_UNLOCK2);
			MODE_PROGRAM: if (roll < 90) begin
				a = pick_addr();
				recent_addrs.push_back(a);
				if (recent_addrs.size() > 16)
					void'(recent_addrs.pop_front());
				return make_access(OP_WRITE, a, 8'($urandom_range(255)));
			end
			MODE_ERASE: begin
				if (roll < 35)
					return make_access(OP_READ, pick_addr(), 8'($urandom_range(255)));
				a = pick_addr();
				// keep the slow erases within budget, aliases included
				if (a == ERASE_LOW_ADDR || a == ERASE_SECT_A || a == ERASE_SECT_B)
					a = a ^ addr_t'(1);
				kind = $urandom_range(2);
				if (roll < 60 && erases_left[kind] > 0) begin
					erases_left[kind]--;
					a = erase_addrs[kind];
				end
				return make_access(OP_WRITE, a, pick_data());
			end
			default: ;
		endcase
		return noise_access();
	endfunction

	task automatic send_access(input req_t r);
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (!req_ready);
		sb.note_access(r);
		if ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < req_idle_pct);
		end
	endtask

	task automatic send_write(addr_t a, logic [7:0] d);
		send_access(make_access(OP_WRITE, a, d));
	endtask

	task automatic send_read(addr_t a);
		send_access(make_access(OP_READ, a, 8'($urandom_range(255))));
	endtask

	task automatic send_unlock();
		send_write(CMD_ADDR1, DATA_UNLOCK1);
		send_write(CMD_ADDR2, DATA_UNLOCK2);
	endtask

	initial begin
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				sb.check_result(rsp);
			rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		req_idle_pct = 0;
		rsp_stall_pct = 0;
		erases_left = '{1, 1, 1};
		erase_addrs = '{ERASE_LOW_ADDR, ERASE_SECT_A, ERASE_SECT_B};
		boundary_addrs = '{19'h00000, 19'h00001, 19'h07ffe, 19'h07fff, 19'h08000,
			19'h1ffff, 19'h20000, 19'h2fffe, 19'h2ffff, 19'h30000,
			19'h3fffe, 19'h3ffff, 19'h40000, 19'h7ffff};
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_access('{op: OP_READ, segment: 8'hff, offset: 16'hffff, write_data: 8'hff});
		send_access('{op: OP_READ, segment: 8'h00, offset: 16'h0000, write_data: 8'h00});
		send_write(19'h12345, DATA_RESET);
		send_write(CMD_ADDR1, 8'h3c);
		send_write(CMD_ADDR1, DATA_UNLOCK1);
		send_write(CMD_ADDR2, 8'h12);
		send_write(CMD_ADDR2, DATA_RESET);
		send_unlock();
		send_write(CMD_ADDR1, DATA_PROGRAM);
		send_write(19'h07fff, 8'h00);
		send_unlock();
		send_write(CMD_ADDR1, DATA_PROGRAM);
		send_write(19'h07ffe, DATA_RESET);
		send_read(19'h07fff);
		send_unlock();
		send_write(CMD_ADDR1, DATA_ERASE);
		send_unlock();
		send_write(ERASE_LOW_ADDR, 8'h30);
		send_write(19'h12345, DATA_RESET);
		send_read(19'h07ffe);
		send_read(19'h07ffe);
		send_read(19'h07fff);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
				1: begin req_idle_pct = 74; rsp_stall_pct = 0;  end
				2: begin req_idle_pct = 0;  rsp_stall_pct = 74; end
				default: begin req_idle_pct = 17; rsp_stall_pct = 17; end
			endcase
			repeat (PHASE_ITEMS)
				send_access(next_random_access());
		end
		req_valid <= 1'b0;

		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.expected_results.size() != 0)
			sb.report_mismatch("results still outstanding at the end");

		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
sv/flci_pkg.sv
sv/flci_ram.sv
sv/flci_cmd.sv
sv/flci_seq.sv
sv/flash_command_interface_top.sv
test/tb_flash_command_interface_top.sv
